@@ rtl/psu_pkg.sv @@
package psu_pkg;

  // Stream widths.
  localparam int IN_W  = 464;
  localparam int OUT_W = 256;

  // Pipeline depth of the top level, output register included.
  localparam int N_STAGES = 7;

  // Elapsed time in seconds, unsigned Q15.16, saturated.
  localparam int DT_W = 31;
  localparam logic [DT_W-1:0] DT_MAX = 31'h7FFF_FFFF;

  // Elapsed milliseconds from which dt saturates: 2^31 * 1000 / 65536.
  localparam logic [31:0] DT_SAT_MS = 32'd32768000;

  // ms -> Q16.16 s splits 1000 into 8 * 125.
  // Quotients by 125 use a reciprocal: ceil(2^32 / 125).
  localparam int          RECIP_SHIFT = 32;
  localparam logic [25:0] RECIP_125   = 26'd34359739;
  localparam logic [6:0]  DIV_PART    = 7'd125;
  // floor(500 / 8): the rounding half, carried through the divide by 8.
  localparam logic [19:0] HALF_DIV8   = 20'd62;

  // Load enables for the three stages of the dt unit.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } psu_dt_en_t;

endpackage

@@ rtl/psu_dt.sv @@
module psu_dt (
  input  logic                        clk,
  input  psu_pkg::psu_dt_en_t         en,
  input  logic [31:0]                 now_ms,
  input  logic [31:0]                 stamp_ms,
  output logic [psu_pkg::DT_W-1:0]    dt,
  output logic                        pend
);

  // Stage 2: elapsed ms, first quotient by 125.
  logic [24:0] e_r;
  logic [18:0] a_r;
  logic        sat_r, pend_r;
  // Stage 3: coarse quotient and fine quotient of the remainder.
  logic [18:0] a3_r;
  logic [13:0] c3_r;
  logic        sat3_r, pend3_r;
  // Stage 4: dt.
  logic [psu_pkg::DT_W-1:0] dt4_r;
  logic                     pend4_r;

  logic [31:0] diff;
  logic [50:0] prod_a;
  logic [25:0] a125;
  logic [6:0]  rem;
  logic [19:0] frac_x;
  logic [45:0] prod_c;
  logic [31:0] dt_sum;

  always_comb begin
    diff   = now_ms - stamp_ms;
    prod_a = 51'(diff[24:0]) * 51'(psu_pkg::RECIP_125);
    a125   = 26'(a_r) * 26'(psu_pkg::DIV_PART);
    rem    = 7'(26'(e_r) - a125);
    frac_x = {rem, 13'b0} + psu_pkg::HALF_DIV8;
    prod_c = 46'(frac_x) * 46'(psu_pkg::RECIP_125);
    dt_sum = {a3_r, 13'b0} + 32'(c3_r);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      e_r    <= diff[24:0];
      a_r    <= prod_a[50:psu_pkg::RECIP_SHIFT];
      sat_r  <= (diff >= psu_pkg::DT_SAT_MS);
      pend_r <= (now_ms < stamp_ms);
    end
    if (en.s3) begin
      a3_r    <= a_r;
      c3_r    <= prod_c[45:psu_pkg::RECIP_SHIFT];
      sat3_r  <= sat_r;
      pend3_r <= pend_r;
    end
    if (en.s4) begin
      dt4_r   <= sat3_r ? psu_pkg::DT_MAX : dt_sum[psu_pkg::DT_W-1:0];
      pend4_r <= pend3_r;
    end
  end

  assign dt   = dt4_r;
  assign pend = pend4_r;

endmodule

@@ rtl/particle_state_update.sv @@
// Channel  Direction  Ports                     Payload
// in       slave      in_tvalid/tready/tdata    one particle record and the current time
// out      master     out_tvalid/tready/tdata   updated record
//                     out_tuser                 pending and freed flags
//
// Seven register stages from input register to output register; one item is
// accepted per cycle while the output is not stalled.
// The length is set by the ms-to-seconds conversion (two reciprocal multiplies)
// followed by the dt squared and acceleration multiplies.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stalled output holds its stage; earlier stages keep filling empty slots.
module particle_state_update (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // now_ms, stamp_ms, color_rgba, color_rate_rgba, position_xy, velocity_xy,
  // accel_xy, drag_factor, size_now, size_rate
  input  logic [psu_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // new_color_rgba, new_position_xy, new_velocity_xy, new_size, new_stamp_ms
  output logic [psu_pkg::OUT_W-1:0]  out_tdata,
  // pending, freed
  output logic [1:0]                 out_tuser
);

  localparam int NS = psu_pkg::N_STAGES;

  typedef struct packed {
    logic [31:0] now;
    logic [31:0] stamp;
    logic [63:0] col;
    logic [63:0] crate;
    logic [63:0] pos;
    logic [63:0] vel;
    logic [63:0] acc;
    logic [31:0] size;
    logic [31:0] srate;
    logic [63:0] drag_t;
    logic        drag_nz;
  } rec_t;

  function automatic logic signed [15:0] sat16(input logic signed [32:0] x);
    if (x > 33'sd32767) return 16'sh7FFF;
    if (x < -33'sd32768) return 16'sh8000;
    return 16'(x);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    if (x > 50'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -50'sd2147483648) return 32'sh8000_0000;
    return 32'(x);
  endfunction

  // Stage valid bits and load enables.
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = ~v_r[NS-1] | out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~v_r[k] | en[k+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Stage 1: input register.
  logic [psu_pkg::IN_W-1:0] in_r;

  always_ff @(posedge clk) begin
    if (en[0]) in_r <= in_tdata;
  end

  // Stage 1 -> 2: velocity times drag (first drag multiply).
  rec_t rec2_nxt, rec2_r, rec3_r, rec4_r;
  logic [15:0] drag1;
  logic signed [48:0] tp;
  logic signed [33:0] tr;

  always_comb begin
    rec2_nxt.now     = in_r[31:0];
    rec2_nxt.stamp   = in_r[63:32];
    rec2_nxt.col     = in_r[127:64];
    rec2_nxt.crate   = in_r[191:128];
    rec2_nxt.pos     = in_r[255:192];
    rec2_nxt.vel     = in_r[319:256];
    rec2_nxt.acc     = in_r[383:320];
    drag1            = in_r[399:384];
    rec2_nxt.size    = in_r[431:400];
    rec2_nxt.srate   = in_r[463:432];
    rec2_nxt.drag_nz = (drag1 != 16'd0);
    for (int k = 0; k < 2; k++) begin
      tp = $signed(rec2_nxt.vel[32*k +: 32]) * $signed({1'b0, drag1});
      tr = 34'((tp + 49'sd16384) >>> 15);
      rec2_nxt.drag_t[32*k +: 32] = sat32(50'(tr));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) rec2_r <= rec2_nxt;
    if (en[2]) rec3_r <= rec2_r;
    if (en[3]) rec4_r <= rec3_r;
  end

  // Stages 2 to 4: elapsed time to dt.
  psu_pkg::psu_dt_en_t      dt_en;
  logic [psu_pkg::DT_W-1:0] dt4;
  logic                     pend4;

  assign dt_en.s2 = en[1];
  assign dt_en.s3 = en[2];
  assign dt_en.s4 = en[3];

  psu_dt u_dt (
    .clk      (clk),
    .en       (dt_en),
    .now_ms   (in_r[31:0]),
    .stamp_ms (in_r[63:32]),
    .dt       (dt4),
    .pend     (pend4)
  );

  // Stage 4 -> 5: every product with dt, dt squared, second drag multiply.
  logic [31:0]              now5_r, stamp5_r, size5_r;
  logic [63:0]              col5_r, pos5_r, vel5_r, acc5_r;
  logic                     pend5_r;
  logic [psu_pkg::DT_W-1:0] dt2_5_r;
  logic signed [31:0]       rc5_r   [4];
  logic signed [47:0]       vdt5_r  [2];
  logic signed [31:0]       nv5_r   [2];
  logic signed [47:0]       sdt5_r;

  logic [psu_pkg::DT_W-1:0] dt2_nxt;
  logic signed [31:0]       rc_nxt  [4];
  logic signed [47:0]       vdt_nxt [2];
  logic signed [31:0]       nv_nxt  [2];
  logic signed [47:0]       sdt_nxt;
  logic signed [31:0]       dtx;
  logic [61:0]              dd;
  logic [45:0]              ddr;
  logic signed [47:0]       cp;
  logic signed [63:0]       vp, sp;
  logic signed [32:0]       omd;
  logic signed [64:0]       np;
  logic signed [48:0]       nvr;

  always_comb begin
    dtx     = $signed({1'b0, dt4});
    dd      = 62'(dt4) * 62'(dt4);
    ddr     = 46'((dd + 62'd32768) >> 16);
    dt2_nxt = (ddr > 46'(psu_pkg::DT_MAX)) ? psu_pkg::DT_MAX : ddr[psu_pkg::DT_W-1:0];
    for (int k = 0; k < 4; k++) begin
      cp        = $signed(rec4_r.crate[16*k +: 16]) * dtx;
      rc_nxt[k] = 32'((cp + 48'sd32768) >>> 16);
    end
    omd = 33'sd65536 - $signed({2'b0, dt4});
    for (int k = 0; k < 2; k++) begin
      vp         = $signed(rec4_r.vel[32*k +: 32]) * dtx;
      vdt_nxt[k] = 48'((vp + 64'sd32768) >>> 16);
      np         = $signed(rec4_r.drag_t[32*k +: 32]) * omd;
      nvr        = 49'((np + 65'sd32768) >>> 16);
      nv_nxt[k]  = rec4_r.drag_nz ? sat32(50'(nvr)) : $signed(rec4_r.vel[32*k +: 32]);
    end
    sp      = $signed(rec4_r.srate) * dtx;
    sdt_nxt = 48'((sp + 64'sd32768) >>> 16);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      now5_r   <= rec4_r.now;
      stamp5_r <= rec4_r.stamp;
      col5_r   <= rec4_r.col;
      pos5_r   <= rec4_r.pos;
      vel5_r   <= rec4_r.vel;
      acc5_r   <= rec4_r.acc;
      size5_r  <= rec4_r.size;
      pend5_r  <= pend4;
      dt2_5_r  <= dt2_nxt;
      rc5_r    <= rc_nxt;
      vdt5_r   <= vdt_nxt;
      nv5_r    <= nv_nxt;
      sdt5_r   <= sdt_nxt;
    end
  end

  // Stage 5 -> 6: acceleration term, color, alpha test, size, partial position.
  logic [31:0]        now6_r, stamp6_r, size6_r, nsize6_r;
  logic [63:0]        col6_r, pos6_r, vel6_r, ncol6_r, nvel6_r;
  logic               pend6_r, dead6_r;
  logic signed [48:0] pp6_r  [2];
  logic signed [47:0] adt6_r [2];

  logic [63:0]        ncol_nxt;
  logic [63:0]        nvel_nxt;
  logic signed [48:0] pp_nxt  [2];
  logic signed [47:0] adt_nxt [2];
  logic signed [31:0] dt2x;
  logic signed [63:0] ap;
  logic signed [32:0] csum;

  always_comb begin
    dt2x = $signed({1'b0, dt2_5_r});
    for (int k = 0; k < 4; k++) begin
      csum = 33'($signed(col5_r[16*k +: 16])) + 33'(rc5_r[k]);
      ncol_nxt[16*k +: 16] = sat16(csum);
    end
    for (int k = 0; k < 2; k++) begin
      ap         = $signed(acc5_r[32*k +: 32]) * dt2x;
      adt_nxt[k] = 48'((ap + 64'sd32768) >>> 16);
      pp_nxt[k]  = 49'($signed(pos5_r[32*k +: 32])) + 49'(vdt5_r[k]);
      nvel_nxt[32*k +: 32] = nv5_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      now6_r   <= now5_r;
      stamp6_r <= stamp5_r;
      col6_r   <= col5_r;
      pos6_r   <= pos5_r;
      vel6_r   <= vel5_r;
      size6_r  <= size5_r;
      pend6_r  <= pend5_r;
      ncol6_r  <= ncol_nxt;
      dead6_r  <= ($signed(ncol_nxt[15:0]) <= 16'sd0);
      nvel6_r  <= nvel_nxt;
      nsize6_r <= sat32(50'($signed(size5_r)) + 50'(sdt5_r));
      pp6_r    <= pp_nxt;
      adt6_r   <= adt_nxt;
    end
  end

  // Stage 6 -> 7: final position and result selection into the output register.
  logic [63:0] npos_nxt;
  logic        freed_nxt;
  logic [psu_pkg::OUT_W-1:0] data_nxt;
  logic [psu_pkg::OUT_W-1:0] out_data_r;
  logic [1:0]                out_user_r;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      npos_nxt[32*k +: 32] = sat32(50'(pp6_r[k]) + 50'(adt6_r[k]));
    end
    freed_nxt = ~pend6_r & dead6_r;
    if (pend6_r) begin
      data_nxt = {stamp6_r, size6_r, vel6_r, pos6_r, col6_r};
    end else if (dead6_r) begin
      data_nxt = {now6_r, 224'd0};
    end else begin
      data_nxt = {now6_r, nsize6_r, nvel6_r, npos_nxt, ncol6_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      out_data_r <= data_nxt;
      out_user_r <= {freed_nxt, pend6_r};
    end
  end

  assign out_tvalid = v_r[NS-1];
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // A pending record is never freed.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("pending and freed both set");

  // A freed particle comes back with a cleared record.
  a_freed_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata[223:0] == 224'd0))
    else $error("freed record not cleared");

  // A live, updated particle keeps a positive alpha.
  a_alpha_live: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0] && !out_tuser[1]) |-> ($signed(out_tdata[15:0]) > 16'sd0))
    else $error("live particle with alpha at or below zero");

  // Input back-pressure only when every stage holds an item.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r))
    else $error("input stalled with an empty stage");

endmodule
